// ===== rtl/core/mctm_pkg.sv =====
// ----------------------------------------------------------------------------
// mctm_pkg
// Shared types and constants for the MIDI clock tempo meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mctm_pkg;

    localparam int STATUS_W   = 8;
    localparam int TIME_W     = 32;
    localparam int CPB_W      = 7;
    localparam int TEMPO_W    = 20;
    localparam int NUM_W      = 34;
    localparam int STEP_W     = 6;

    localparam logic [STATUS_W-1:0] CLOCK_BYTE = 8'hF8;
    localparam logic [CPB_W-1:0]    CPB_RESET  = 7'd24;

    // 60e6 us per minute, times 256 for the 12.8 format
    localparam logic [NUM_W-1:0]    TEMPO_NUM  = 34'd15360000000;
    localparam logic [TEMPO_W-1:0]  TEMPO_MAX  = '1;

    // divider result, handed back to the sequencer
    typedef struct packed {
        logic               done;
        logic [TEMPO_W-1:0] quo;
    } t_div_res;

endpackage

`default_nettype wire

// ===== rtl/core/mctm_div.sv =====
// ----------------------------------------------------------------------------
// mctm_div
// Restoring divider of the fixed tempo numerator by a 32-bit sum, one
// quotient bit per cycle, quotient saturated to 20 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mctm_div
    import mctm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [TIME_W-1:0] i_den,
    output t_div_res               o_res
);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_cnt,  n_cnt;
    logic [TIME_W-1:0]   r_den,  n_den;
    logic [TIME_W-1:0]   r_rem,  n_rem;
    logic [TEMPO_W-1:0]  r_quo,  n_quo;
    logic                r_ovf,  n_ovf;

    logic [TIME_W:0]     trial;
    logic [TIME_W:0]     diff;
    logic                ge;

    // one compare/subtract per cycle
    assign trial = {r_rem, TEMPO_NUM[r_cnt]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_ovf  = r_ovf;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(NUM_W - 1);
            n_den  = i_den;
            n_rem  = '0;
            n_quo  = '0;
            n_ovf  = 1'b0;
        end else if (r_busy) begin
            n_rem = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            n_quo = {r_quo[TEMPO_W-2:0], ge};
            // any bit pushed past bit 19 means the tempo is out of range
            n_ovf = r_ovf | r_quo[TEMPO_W-1];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_ovf <= n_ovf;
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_ovf ? TEMPO_MAX : r_quo;

endmodule

`default_nettype wire

// ===== rtl/core/midi_clock_tempo_meter.sv =====
// ----------------------------------------------------------------------------
// midi_clock_tempo_meter
// Tempo meter driven by MIDI timing-clock bytes with microsecond timestamps.
// ----------------------------------------------------------------------------
// Each input beat carries the last byte of a MIDI message and its arrival
// time. Only timing clocks (0xF8) produce an output beat; other bytes are
// accepted in idle and dropped. The first clock after reset only records
// its time and reports zeros. Each later clock reports the wrapping interval
// since the previous clock and adds it to a saturating sum; once
// clocks_per_beat clocks are summed, the output beat also carries
// tempo_valid = 1 and the tempo 15,360,000,000 / sum in 12.8 bpm, saturated
// to 1048575, and the count and sum restart. Other clocks go straight from
// idle to the emit state; a clock that closes a beat first waits in the
// divide state for the 34-step bit-serial divider. The input is held off
// while an item is in progress, but a new item is accepted while the previous
// result waits in the output register. The user must write clocks_per_beat
// through the cfg channel while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_clock_tempo_meter
    import mctm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // configuration: clocks_per_beat
    input  wire logic        i_cfg_valid,
    input  wire logic [7:0]  i_cfg_data,     // [6:0] clocks_per_beat
    output logic             o_cfg_ready,

    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [7:0] status_byte, [39:8] time_us

    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [31:0] interval_us,
                                             // [51:32] tempo_bpm_q8, [55:52] zero
    output logic             m_axis_tuser    // [0] tempo_valid
);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state              r_state, n_state;

    // tempo tracking state
    logic [CPB_W-1:0]    r_cpb, n_cpb;
    logic [TIME_W-1:0]   r_last_time, n_last_time;
    logic                r_seen, n_seen;
    logic [CPB_W-1:0]    r_count, n_count;
    logic [TIME_W-1:0]   r_sum, n_sum;

    // result being built
    logic [TIME_W-1:0]   r_pend_ivl, n_pend_ivl;
    logic                r_pend_tv, n_pend_tv;
    logic [TEMPO_W-1:0]  r_pend_tempo, n_pend_tempo;

    // output register
    logic                r_out_valid, n_out_valid;
    logic [TIME_W-1:0]   r_out_ivl, n_out_ivl;
    logic                r_out_tv, n_out_tv;
    logic [TEMPO_W-1:0]  r_out_tempo, n_out_tempo;

    logic                div_start;
    logic [TIME_W-1:0]   div_den;
    t_div_res            div_res;

    logic [STATUS_W-1:0] in_status;
    logic [TIME_W-1:0]   in_time;
    logic                in_acc;
    logic                out_acc;
    logic [TIME_W-1:0]   interval;
    logic [TIME_W:0]     sum_wide;
    logic [CPB_W-1:0]    count_inc;

    assign in_status = s_axis_tdata[7:0];
    assign in_time   = s_axis_tdata[39:8];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = r_out_valid && m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // interval and saturating accumulate
    assign interval  = in_time - r_last_time;
    assign sum_wide  = {1'b0, r_sum} + {1'b0, interval};
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_cpb        = r_cpb;
        n_last_time  = r_last_time;
        n_seen       = r_seen;
        n_count      = r_count;
        n_sum        = r_sum;
        n_pend_ivl   = r_pend_ivl;
        n_pend_tv    = r_pend_tv;
        n_pend_tempo = r_pend_tempo;
        n_out_valid  = r_out_valid;
        n_out_ivl    = r_out_ivl;
        n_out_tv     = r_out_tv;
        n_out_tempo  = r_out_tempo;
        div_start    = 1'b0;
        div_den      = r_sum;

        if (i_cfg_valid) begin
            n_cpb = i_cfg_data[CPB_W-1:0];
        end

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc && in_status == CLOCK_BYTE) begin
                    n_last_time = in_time;
                    if (!r_seen) begin
                        // first clock: just remember when it came
                        n_seen       = 1'b1;
                        n_pend_ivl   = '0;
                        n_pend_tv    = 1'b0;
                        n_pend_tempo = '0;
                        n_state      = ST_EMIT;
                    end else begin
                        n_pend_ivl = interval;
                        if (count_inc >= r_cpb) begin
                            // beat complete: divide the full sum, restart
                            div_start = 1'b1;
                            div_den   = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
                            n_count   = '0;
                            n_sum     = '0;
                            n_pend_tv = 1'b1;
                            n_state   = ST_DIV;
                        end else begin
                            n_count      = count_inc;
                            n_sum        = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
                            n_pend_tv    = 1'b0;
                            n_pend_tempo = '0;
                            n_state      = ST_EMIT;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    n_pend_tempo = div_res.quo;
                    n_state      = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hand over once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_ivl   = r_pend_ivl;
                    n_out_tv    = r_pend_tv;
                    n_out_tempo = r_pend_tempo;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cpb       <= CPB_RESET;
            r_last_time <= '0;
            r_seen      <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cpb       <= n_cpb;
            r_last_time <= n_last_time;
            r_seen      <= n_seen;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_pend_ivl   <= n_pend_ivl;
        r_pend_tv    <= n_pend_tv;
        r_pend_tempo <= n_pend_tempo;
        r_out_ivl    <= n_out_ivl;
        r_out_tv     <= n_out_tv;
        r_out_tempo  <= n_out_tempo;
    end

    // bit-serial divider
    mctm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (div_den),
        .o_res   (div_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_tempo, r_out_ivl};
    assign m_axis_tuser  = r_out_tv;

    // a clock byte taken in idle always leaves idle
    a_clock_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_status == CLOCK_BYTE) |=> (r_state != ST_IDLE))
        else $error("clock beat did not start processing");

    // divider only finishes while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == ST_DIV))
        else $error("divider result outside divide state");

    // no fresh tempo means a zero tempo field
    a_tempo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_tv) |-> (r_out_tempo == '0))
        else $error("stale tempo on output");

    // closing a beat clears the count and the sum
    a_count_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_count == '0 && r_sum == '0))
        else $error("beat end did not clear accumulator");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MIDI clock tempo meter.
// ----------------------------------------------------------------------------
// An initial block queues MIDI bytes with timestamps and clocks_per_beat
// writes. A clocked driver presents them with random gaps. A behavioral
// tempo tracker predicts one output beat per accepted timing clock. A clocked
// monitor applies random back-pressure and checks each output beat against
// the oldest prediction. The stimulus starts with wrap, saturation and
// register corner cases. It then runs steady clock trains with jitter and
// noise bytes under several clocks_per_beat settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mctm_pkg::*;

    localparam int SETTLE_CYC = 48;       // covers the divider after the last output beat
    localparam int TAIL_CYC   = 60;
    localparam int LIMIT_CYC  = 800000;
    localparam int HOLD_AT    = 310;      // accepted beats before the long receiver stall
    localparam int HOLD_CYC   = 3000;

    typedef enum logic [1:0] {
        REQ_BYTE,                         // one MIDI byte with its timestamp
        REQ_CFG,                          // clocks_per_beat write, block idle
        REQ_SYNC                          // pause until every result is back
    } t_req_kind;

    typedef struct {
        t_req_kind   kind;
        logic [7:0]  status;
        logic [31:0] stamp;
        logic [7:0]  cfg;
    } t_midi_req;

    typedef struct {
        logic [31:0]        interval;
        logic               fresh;
        logic [TEMPO_W-1:0] bpm;
    } t_tempo_rec;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [7:0]  i_cfg_data    = '0;
    logic        o_cfg_ready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    t_midi_req  pend_q[$];
    t_tempo_rec tempo_q[$];

    // tempo tracker state
    logic [CPB_W-1:0] beat_len   = CPB_RESET;
    logic [31:0]      prev_stamp = '0;
    logic             have_first = 1'b0;
    logic [CPB_W-1:0] tick_cnt   = '0;
    logic [31:0]      span_sum   = '0;

    logic [31:0] cyc       = '0;
    logic [31:0] clk_stamp = '0;
    int          beats_in  = 0;
    int          beats_out = 0;
    int          bad_beats = 0;
    int          tx_gap    = 0;
    int          tx_settle = 0;
    int          rx_gap    = 0;
    logic        nxt_tvalid;
    logic        nxt_cfg;
    logic        nxt_ready;
    logic        rx_hold   = 1'b0;
    logic        tx_calm;
    logic        rx_calm;

    midi_clock_tempo_meter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stretches without any idling on either side
    assign tx_calm = (cyc[10:9] == 2'b11);
    assign rx_calm = (cyc[11:10] == 2'b10);

    function automatic int pick_gap(logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // expected output beat for one accepted byte, none for non-clock bytes
    function automatic void track_byte(logic [7:0] status, logic [31:0] stamp);
        t_tempo_rec rec;
        logic [32:0] wide;
        logic [63:0] quot;
        if (status != CLOCK_BYTE) return;
        rec.interval = '0;
        rec.fresh    = 1'b0;
        rec.bpm      = '0;
        if (!have_first) begin
            have_first = 1'b1;
            prev_stamp = stamp;
            tempo_q.push_back(rec);
            return;
        end
        rec.interval = stamp - prev_stamp;
        prev_stamp   = stamp;
        wide         = {1'b0, span_sum} + {1'b0, rec.interval};
        span_sum     = wide[32] ? '1 : wide[31:0];
        tick_cnt     = tick_cnt + 1'b1;
        if (tick_cnt >= beat_len) begin
            rec.fresh = 1'b1;
            if (span_sum == '0) begin
                rec.bpm = TEMPO_MAX;
            end else begin
                quot    = 64'(TEMPO_NUM) / 64'(span_sum);
                rec.bpm = (quot > 64'(TEMPO_MAX)) ? TEMPO_MAX : quot[TEMPO_W-1:0];
            end
            tick_cnt = '0;
            span_sum = '0;
        end
        tempo_q.push_back(rec);
    endfunction

    task automatic check_beat();
        t_tempo_rec want;
        beats_out++;
        if (tempo_q.size() == 0) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("output beat %0d with nothing expected: interval %0d valid %0b tempo %0d",
                         beats_out, m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[51:32]);
            return;
        end
        want = tempo_q.pop_front();
        if (m_axis_tdata[31:0] !== want.interval || m_axis_tuser !== want.fresh ||
            m_axis_tdata[51:32] !== want.bpm) begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("output beat %0d: expected interval %0d valid %0b tempo %0d, got %0d %0b %0d",
                         beats_out, want.interval, want.fresh, want.bpm,
                         m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[51:32]);
        end
    endtask

    task automatic add_byte(logic [7:0] status, logic [31:0] stamp);
        t_midi_req r;
        r.kind   = REQ_BYTE;
        r.status = status;
        r.stamp  = stamp;
        r.cfg    = '0;
        pend_q.push_back(r);
    endtask

    task automatic add_tick(logic [31:0] step);
        clk_stamp = clk_stamp + step;
        add_byte(CLOCK_BYTE, clk_stamp);
    endtask

    task automatic add_ctl(t_req_kind kind, logic [7:0] value);
        t_midi_req r;
        r.kind   = kind;
        r.status = '0;
        r.stamp  = '0;
        r.cfg    = value;
        pend_q.push_back(r);
    endtask

    // steady clock train with jitter, odd intervals and noise bytes
    task automatic fill_phase(logic [7:0] cpb, int n);
        int period;
        int pick;
        add_ctl(REQ_CFG, cpb);
        period = $urandom_range(500, 60000);
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                add_byte(8'($urandom_range(0, 255)), clk_stamp + $urandom_range(0, 300));
            else if (pick < 80)
                add_tick(32'(period + int'($urandom_range(0, 200)) - 100));
            else if (pick < 88)
                add_tick($urandom_range(0, 50));
            else if (pick < 94)
                add_tick($urandom);
            else
                add_tick(32'h8000_0000 | $urandom);
        end
    endtask

    // sender: one beat or one register write in flight at a time
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid   <= 1'b0;
            tx_gap    = 0;
            tx_settle = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_byte(pend_q[0].status, pend_q[0].stamp);
                void'(pend_q.pop_front());
                beats_in++;
                tx_gap = pick_gap(tx_calm);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                beat_len = pend_q[0].cfg[CPB_W-1:0];
                void'(pend_q.pop_front());
                tx_settle = 0;
            end
            nxt_tvalid = 1'b0;
            nxt_cfg    = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pend_q.size() != 0) begin
                case (pend_q[0].kind)
                    REQ_BYTE: begin
                        nxt_tvalid = 1'b1;
                    end
                    default: begin
                        // writes and pauses wait for an idle block
                        if (tempo_q.size() != 0) begin
                            tx_settle = 0;
                        end else if (tx_settle < SETTLE_CYC) begin
                            tx_settle++;
                        end else if (pend_q[0].kind == REQ_CFG) begin
                            nxt_cfg = 1'b1;
                        end else begin
                            void'(pend_q.pop_front());
                            tx_settle = 0;
                        end
                    end
                endcase
            end
            s_axis_tvalid <= nxt_tvalid;
            i_cfg_valid   <= nxt_cfg;
            if (pend_q.size() != 0) begin
                s_axis_tdata <= {pend_q[0].stamp, pend_q[0].status};
                i_cfg_data   <= pend_q[0].cfg;
            end
        end
    end

    // receiver: random back-pressure and checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_beat();
                rx_gap = pick_gap(rx_calm);
            end else if (rx_gap == 0 && $urandom_range(0, 19) == 0) begin
                rx_gap = pick_gap(rx_calm);
            end
            if (rx_hold) begin
                nxt_ready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_axis_tready <= nxt_ready;
        end
    end

    // one long receiver stall while the sender keeps offering bytes
    initial begin
        wait (beats_in >= HOLD_AT);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT_CYC) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        // non-clock bytes leave the state alone
        add_byte(8'h00, 32'h0000_0000);
        add_byte(8'hFF, 32'hFFFF_FFFF);
        add_byte(8'hF7, 32'h0000_0001);
        add_byte(8'hF9, 32'h0000_0002);
        add_byte(8'h80, 32'h0000_0003);
        // first clock only records its time
        clk_stamp = 32'hFFFF_FFF0;
        add_byte(CLOCK_BYTE, clk_stamp);
        // one clock per beat: wrapped interval, zero sum, largest interval
        add_ctl(REQ_CFG, 8'd1);
        add_tick(32'h20);
        add_tick(32'h0);
        add_tick(32'hFFFF_FFFF);
        // sum saturates over two intervals
        add_ctl(REQ_CFG, 8'd2);
        add_tick(32'hFFFF_FFFF);
        add_tick(32'hFFFF_FFFF);
        // zero setting acts as one
        add_ctl(REQ_CFG, 8'd0);
        add_tick(32'd20833);
        add_tick(32'd20833);
        // lowering the setting mid-beat closes it at the next clock
        add_ctl(REQ_CFG, 8'd10);
        repeat (4) add_tick(32'd20833);
        add_ctl(REQ_CFG, 8'd2);
        add_tick(32'd20833);

        fill_phase(8'd1, 130);
        fill_phase(8'd96, 130);
        fill_phase(8'hFF, 130);
        fill_phase(8'd0, 130);
        fill_phase(8'd5, 65);
        add_ctl(REQ_SYNC, 8'd0);
        fill_phase(8'd5, 65);
        fill_phase(CPB_RESET, 130);
        fill_phase(8'($urandom_range(1, 96)), 130);
        fill_phase(8'd3, 130);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pend_q.size() != 0 || tempo_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (bad_beats == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mctm_pkg.sv
rtl/core/mctm_div.sv
rtl/core/midi_clock_tempo_meter.sv
test/tb.sv
